// File: design/apo_pkg.sv
// Shared types and constants for the antialiased pulse oscillator.
// Used by every design file; depends on nothing.
package apo_pkg;

  // Phase fraction bits (Q0.PHASE_BITS) and sample width (Q1.(SAMPLE_BITS-1)).
  localparam int PHASE_BITS  = 24;
  localparam int SAMPLE_BITS = 16;

  localparam int IN_DATA_W  = ((PHASE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CFG_DATA_W = (PHASE_BITS > SAMPLE_BITS) ? PHASE_BITS : SAMPLE_BITS;
  localparam int CFG_IDX_W  = 3;

  // Signed width for the level numerator, and the divider step counter.
  localparam int LNUM_W = PHASE_BITS + 3;
  localparam int CNT_W  = $clog2(SAMPLE_BITS);

  // Depth of the queue between front and back; must be a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_THRESHOLD       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_FREQUENCY      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_STREAM_FREQUENCY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE            = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DC_OFFSET            = 3'd4;

  // Phase 1.0 in the PHASE_BITS+1 bit state, duty reset 0.5.
  localparam logic [PHASE_BITS:0]   PH_ONE     = (PHASE_BITS + 1)'(1) << PHASE_BITS;
  localparam logic [PHASE_BITS-1:0] DUTY_RESET = PHASE_BITS'(1) << (PHASE_BITS - 1);

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  typedef struct packed {
    logic [PHASE_BITS-1:0]         duty_threshold;
    logic [PHASE_BITS-1:0]         fixed_frequency;
    logic                          use_stream_frequency;
    logic signed [SAMPLE_BITS-1:0] amplitude;
    logic signed [SAMPLE_BITS-1:0] dc_offset;
  } apo_cfg_t;

  // One classified tick: zero marks a cleared phase (output the offset),
  // otherwise level = (neg ? -mag : mag) / freq.
  typedef struct packed {
    logic                  zero;
    logic                  neg;
    logic [PHASE_BITS-1:0] mag;
    logic [PHASE_BITS-1:0] freq;
  } apo_entry_t;

endpackage

// File: design/apo_front.sv
// Front end: accepts ticks, selects the frequency, tracks the phase and
// forms the level numerator. Depends on apo_pkg.
module apo_front import apo_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  input  apo_cfg_t             cfg,
  input  logic                 q_full,
  output logic                 push,
  output apo_entry_t           push_entry
);

  logic [PHASE_BITS:0]   phase_r, phase_nxt;
  logic [PHASE_BITS-1:0] freq;
  logic                  invalid;
  logic                  zero;
  logic [PHASE_BITS-1:0] p;
  logic [PHASE_BITS:0]   step_sum;
  logic [PHASE_BITS:0]   gap_fall;
  logic [PHASE_BITS-1:0] gap_rise;
  logic [LNUM_W-1:0]     lnum;
  logic [LNUM_W-1:0]     lnum_abs;

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  always_comb begin
    freq    = cfg.use_stream_frequency ? in_tdata[PHASE_BITS-1:0] : cfg.fixed_frequency;
    invalid = cfg.use_stream_frequency && in_tuser;
    zero    = invalid || (freq == '0);
    // Wrap once: dropping the 1.0 bit subtracts 1.0.
    p        = phase_r[PHASE_BITS-1:0];
    step_sum = {1'b0, p} + {1'b0, freq};
    gap_fall = PH_ONE - {1'b0, p};
    gap_rise = cfg.duty_threshold - p;
    if (p >= cfg.duty_threshold) begin
      if (step_sum > PH_ONE) begin
        lnum = {1'b0, gap_fall, 1'b0} - {3'b000, freq};
      end else begin
        lnum = {3'b000, freq};
      end
    end else begin
      if (step_sum > {1'b0, cfg.duty_threshold}) begin
        lnum = {3'b000, freq} - {2'b00, gap_rise, 1'b0};
      end else begin
        lnum = '0 - {3'b000, freq};
      end
    end
    lnum_abs = lnum[LNUM_W-1] ? ('0 - lnum) : lnum;

    push_entry.zero = zero;
    push_entry.neg  = lnum[LNUM_W-1];
    push_entry.mag  = lnum_abs[PHASE_BITS-1:0];
    push_entry.freq = freq;

    phase_nxt = phase_r;
    if (push) begin
      phase_nxt = zero ? '0 : step_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

// File: design/apo_queue.sv
// Short FIFO of classified ticks between front and back.
// Depends on apo_pkg.
module apo_queue import apo_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  apo_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output apo_entry_t head
);

  apo_entry_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// File: design/apo_back.sv
// Back end: scales the level by the amplitude, divides by the frequency
// one quotient bit a cycle, adds the offset and saturates. Depends on apo_pkg.
module apo_back import apo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  apo_cfg_t              cfg,
  input  logic                  q_valid,
  input  apo_entry_t            q_head,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  localparam int PROD_W = PHASE_BITS + SAMPLE_BITS;

  state_t                 state_r, state_nxt;
  apo_entry_t             ent_r;
  logic [PROD_W-1:0]      prod_r;
  logic [PHASE_BITS-1:0]  rem_r;
  logic [SAMPLE_BITS-1:0] qsh_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_data_r;

  logic [SAMPLE_BITS-1:0] amag;
  logic [PROD_W-1:0]      dvd;
  logic [PHASE_BITS+1:0]  diff;
  logic                   ge;
  logic                   neg;
  logic [SAMPLE_BITS+1:0] qval, sval, total;
  logic [SAMPLE_BITS-1:0] result;
  logic                   load_out;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);
  assign pop        = (state_r == ST_IDLE) && q_valid;
  assign load_out   = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    amag = cfg.amplitude[SAMPLE_BITS-1] ? ('0 - cfg.amplitude) : cfg.amplitude;
    // Add half the divisor for rounding; the quotient fits SAMPLE_BITS.
    dvd  = prod_r + PROD_W'(ent_r.freq[PHASE_BITS-1:1]);
    diff = {1'b0, rem_r, qsh_r[SAMPLE_BITS-1]} - {2'b00, ent_r.freq};
    ge   = !diff[PHASE_BITS+1];

    neg   = ent_r.neg ^ cfg.amplitude[SAMPLE_BITS-1];
    qval  = {2'b00, qsh_r};
    sval  = neg ? ('0 - qval) : qval;
    total = sval + {{2{cfg.dc_offset[SAMPLE_BITS-1]}}, cfg.dc_offset};
    if (ent_r.zero) begin
      result = cfg.dc_offset;
    end else if ((total[SAMPLE_BITS+1:SAMPLE_BITS-1] == '0) ||
                 (total[SAMPLE_BITS+1:SAMPLE_BITS-1] == '1)) begin
      result = total[SAMPLE_BITS-1:0];
    end else if (total[SAMPLE_BITS+1]) begin
      result = SAMPLE_MIN;
    end else begin
      result = SAMPLE_MAX;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = q_head.zero ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == CNT_W'(SAMPLE_BITS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          ent_r <= q_head;
        end
      end
      ST_MUL: begin
        prod_r <= PROD_W'(ent_r.mag) * PROD_W'(amag);
      end
      ST_PREP: begin
        rem_r <= dvd[PROD_W-1:SAMPLE_BITS];
        qsh_r <= dvd[SAMPLE_BITS-1:0];
        cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r <= ge ? diff[PHASE_BITS-1:0] : {rem_r[PHASE_BITS-2:0], qsh_r[SAMPLE_BITS-1]};
        qsh_r <= {qsh_r[SAMPLE_BITS-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_data_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: design/antialiased_pulse_oscillator.sv
// Top level of the antialiased pulse oscillator: configuration registers,
// front end, tick queue and back end. Depends on apo_pkg, apo_front,
// apo_queue and apo_back.
//
//   Channel  Direction  Handshake            Payload
//   in_      slave      in_tvalid/in_tready  tdata: tick_frequency; tuser: frequency_invalid
//   out_     master     out_tvalid/out_tready tdata: sample
//   cfg_     write      cfg_wr_en            cfg_index, cfg_wdata
//
// The front takes one tick per cycle while the queue has room and advances
// the phase at once. The back handles one tick at a time and pops the queue
// only in its idle state: a tick with a nonzero frequency passes through its
// multiply, prepare, divide and done states, its restoring divider producing one
// quotient bit a cycle; a tick with zero or invalid frequency goes from idle to done.
// Reset (rst_n low, synchronous) clears the phase, the queue, the back state
// and the output valid, and loads the register reset values.
// A stalled output holds its sample; the back waits in its final state and
// the queue absorbs up to QUEUE_DEPTH ticks before in_tready drops.
module antialiased_pulse_oscillator import apo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [PHASE_BITS-1:0] tick_frequency, rest zero
  input  logic                  in_tuser,   // [0] frequency_invalid
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [SAMPLE_BITS-1:0] sample, rest zero
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  apo_cfg_t   cfg_r;
  logic       push;
  apo_entry_t push_entry;
  logic       q_full;
  logic       q_valid;
  apo_entry_t q_head;
  logic       pop;

  // Configuration registers; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty_threshold       <= DUTY_RESET;
      cfg_r.fixed_frequency      <= '0;
      cfg_r.use_stream_frequency <= 1'b0;
      cfg_r.amplitude            <= SAMPLE_MAX;
      cfg_r.dc_offset            <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DUTY_THRESHOLD:       cfg_r.duty_threshold       <= cfg_wdata[PHASE_BITS-1:0];
        CFG_FIXED_FREQUENCY:      cfg_r.fixed_frequency      <= cfg_wdata[PHASE_BITS-1:0];
        CFG_USE_STREAM_FREQUENCY: cfg_r.use_stream_frequency <= cfg_wdata[0];
        CFG_AMPLITUDE:            cfg_r.amplitude            <= cfg_wdata[SAMPLE_BITS-1:0];
        CFG_DC_OFFSET:            cfg_r.dc_offset            <= cfg_wdata[SAMPLE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Classify each tick and advance the phase.
  apo_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg        (cfg_r),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // Hold classified ticks until the back end is free.
  apo_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  // Scale, divide, offset and saturate; drive the output register.
  apo_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: design/apo_checker.sv
// Port-level checks for the antialiased pulse oscillator, bound to the top.
// Depends on apo_pkg and antialiased_pulse_oscillator.
module apo_checker import apo_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // A pending sample stays offered until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // A stalled sample keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Reset empties the queue, so ticks are taken right after it.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind antialiased_pulse_oscillator apo_checker u_apo_checker (.*);
